@@ rtl/ets_pkg.sv @@
// Package for the EDF task tick scheduler: field widths, command and result codes,
// the register map and the control bundle that drives each task cell.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package ets_pkg;

   localparam int CMD_W        = 1;
   localparam int TASK_INDEX_W = 3;
   localparam int PARAM_W      = 16;
   localparam int KIND_W       = 1;
   localparam int RUN_TASK_W   = 3;
   localparam int MISS_W       = 8;
   localparam int COUNT_W      = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
   localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] ADDR_TASK_COUNT  = 3'd0;
   localparam logic [COUNT_W-1:0]    TASK_COUNT_RESET = 4'd1;

   typedef struct packed {
      logic load;    // write new task parameters and start a fresh job
      logic commit;  // apply the end-of-tick update
      logic win;     // this cell was selected to run on the committed tick
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/ets_req_if.sv @@
// Request channel of the EDF task tick scheduler: valid/ready plus one input item.
// Depends on ets_pkg for the field widths.
`default_nettype none

interface ets_req_if;
   logic                              valid;
   logic                              ready;
   logic [ets_pkg::CMD_W-1:0]         cmd;
   logic [ets_pkg::TASK_INDEX_W-1:0]  task_index;
   logic [ets_pkg::PARAM_W-1:0]       exec_time;
   logic [ets_pkg::PARAM_W-1:0]       rel_deadline;
   logic [ets_pkg::PARAM_W-1:0]       period;

   modport source (output valid, cmd, task_index, exec_time, rel_deadline, period,
                   input ready);
   modport sink   (input valid, cmd, task_index, exec_time, rel_deadline, period,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/ets_rsp_if.sv @@
// Response channel of the EDF task tick scheduler: valid/ready plus one result item.
// Depends on ets_pkg for the field widths.
`default_nettype none

interface ets_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ets_pkg::KIND_W-1:0]       result_kind;
   logic                             run_valid;
   logic [ets_pkg::RUN_TASK_W-1:0]   run_task;
   logic [ets_pkg::MISS_W-1:0]       miss_mask;

   modport source (output valid, result_kind, run_valid, run_task, miss_mask,
                   input ready);
   modport sink   (input valid, result_kind, run_valid, run_task, miss_mask,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/ets_cell.sv @@
// One task cell: holds the parameters and job state of a single task slot and
// forms one stage of the registered selection chain. Depends on ets_pkg.
`default_nettype none

module ets_cell #(
   parameter int               TIME_WIDTH = 16,
   parameter int               IDX_W      = 3,
   parameter logic [IDX_W-1:0] CELL_IDX   = '0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ets_pkg::cell_ctrl_type    ctrl,
   input  wire logic                      active,
   input  wire logic [TIME_WIDTH-1:0]     load_exec,
   input  wire logic [TIME_WIDTH-1:0]     load_deadline,
   input  wire logic [TIME_WIDTH-1:0]     load_period,
   input  wire logic                      scan_in_found,
   input  wire logic [TIME_WIDTH-1:0]     scan_in_best,
   input  wire logic [IDX_W-1:0]          scan_in_pick,
   output logic                           scan_out_found,
   output logic [TIME_WIDTH-1:0]          scan_out_best,
   output logic [IDX_W-1:0]               scan_out_pick,
   output logic                           miss
);

   logic [TIME_WIDTH-1:0] exec_ff, exec_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic [TIME_WIDTH-1:0] remaining_ff, remaining_in;
   logic [TIME_WIDTH-1:0] dl_left_ff, dl_left_in;
   logic [TIME_WIDTH-1:0] phase_ff, phase_in;
   logic                  found_ff, found_in;
   logic [TIME_WIDTH-1:0] best_ff, best_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;

   logic                  candidate;
   logic                  period_end;
   logic [TIME_WIDTH-1:0] remaining_dec;

   // This cell takes over the running best when it has work left and a strictly
   // earlier deadline, so the lowest index keeps a tie.
   always_comb begin
      candidate = active && (remaining_ff != '0) &&
                  (!scan_in_found || (dl_left_ff < scan_in_best));
      if (candidate) begin
         found_in = 1'b1;
         best_in  = dl_left_ff;
         pick_in  = CELL_IDX;
      end else begin
         found_in = scan_in_found;
         best_in  = scan_in_best;
         pick_in  = scan_in_pick;
      end
   end

   always_comb begin
      remaining_dec = ctrl.win ? (remaining_ff - TIME_WIDTH'(1)) : remaining_ff;
      period_end    = (period_ff != '0) && (phase_ff == (period_ff - TIME_WIDTH'(1)));
      miss          = ctrl.commit && active && !period_end &&
                      (dl_left_ff == '0) && (remaining_dec != '0);

      exec_in      = exec_ff;
      deadline_in  = deadline_ff;
      period_in    = period_ff;
      remaining_in = remaining_ff;
      dl_left_in   = dl_left_ff;
      phase_in     = phase_ff;

      if (ctrl.load) begin
         exec_in      = load_exec;
         deadline_in  = load_deadline;
         period_in    = load_period;
         remaining_in = load_exec;
         dl_left_in   = load_deadline;
         phase_in     = '0;
      end else if (ctrl.commit) begin
         remaining_in = remaining_dec;
         if (active) begin
            if (period_end) begin
               remaining_in = exec_ff;
               dl_left_in   = deadline_ff;
               phase_in     = '0;
            end else begin
               if (dl_left_ff != '0) begin
                  dl_left_in = dl_left_ff - TIME_WIDTH'(1);
               end
               phase_in = phase_ff + TIME_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff      <= '0;
         deadline_ff  <= '0;
         period_ff    <= '0;
         remaining_ff <= '0;
         dl_left_ff   <= '0;
         phase_ff     <= '0;
         found_ff     <= 1'b0;
         best_ff      <= '0;
         pick_ff      <= '0;
      end else begin
         exec_ff      <= exec_in;
         deadline_ff  <= deadline_in;
         period_ff    <= period_in;
         remaining_ff <= remaining_in;
         dl_left_ff   <= dl_left_in;
         phase_ff     <= phase_in;
         found_ff     <= found_in;
         best_ff      <= best_in;
         pick_ff      <= pick_in;
      end
   end

   assign scan_out_found = found_ff;
   assign scan_out_best  = best_ff;
   assign scan_out_pick  = pick_ff;

endmodule

`default_nettype wire

@@ rtl/edf_task_tick_scheduler.sv @@
// Top level of the EDF task tick scheduler: task count register, transaction control,
// response register and the row of task cells. Depends on ets_pkg, ets_req_if,
// ets_rsp_if and ets_cell.
//
//   Port group   Direction  Carries
//   req_chan     in         one load or tick transaction (cmd, task_index, parameters)
//   rsp_chan     out        one result per request (kind, run_valid, run_task, miss_mask)
//   csr_*        in/out     APB-style access to task_count at byte address 0
//
// A load's acknowledge is registered and is in the response register on the next
// cycle. For a tick, the selection travels through the chain of task cells one
// register per cell, then the ST_COMMIT state commits the update. Reset is
// synchronous and restores every task slot to zero and task_count to one. A
// stalled response holds the commit, and no new request is taken until the
// response register is free.
`default_nettype none

module edf_task_tick_scheduler #(
   parameter int NUM_TASKS  = 8,
   parameter int TIME_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ets_req_if.sink                                req_chan,
   ets_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ets_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ets_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [ets_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CMP_W = IDX_W + ets_pkg::COUNT_W;
   localparam int SEL_W = (IDX_W > ets_pkg::TASK_INDEX_W) ? IDX_W : ets_pkg::TASK_INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [ets_pkg::COUNT_W-1:0] task_count_ff, task_count_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ets_pkg::KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic                               rsp_run_ff, rsp_run_in;
   logic [ets_pkg::RUN_TASK_W-1:0]     rsp_task_ff, rsp_task_in;
   logic [ets_pkg::MISS_W-1:0]         rsp_miss_ff, rsp_miss_in;

   logic out_free, req_fire, load_go, commit_go, csr_write;

   logic                  chain_found [NUM_TASKS+1];
   logic [TIME_WIDTH-1:0] chain_best  [NUM_TASKS+1];
   logic [IDX_W-1:0]      chain_pick  [NUM_TASKS+1];
   logic [NUM_TASKS-1:0]  win_vec;
   logic [NUM_TASKS-1:0]  miss_vec;
   logic [ets_pkg::MISS_W-1:0] miss_mask_w;

   logic [TIME_WIDTH-1:0] load_exec, load_deadline, load_period;

   // ---------------------------------------------------------------- csr
   assign csr_write = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr == ets_pkg::ADDR_TASK_COUNT);
   assign task_count_in = csr_write ? csr_pwdata[ets_pkg::COUNT_W-1:0] : task_count_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ets_pkg::ADDR_TASK_COUNT) ?
                       ets_pkg::CSR_DATA_W'(task_count_ff) : '0;

   // ---------------------------------------------------------------- control
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign load_go   = req_fire && (req_chan.cmd == ets_pkg::CMD_LOAD);
   assign commit_go = (state_ff == ST_COMMIT) && out_free;

   // The chain result is settled by the time the scan counter moves the state to
   // ST_COMMIT, because no task state changes in the meantime.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire && (req_chan.cmd == ets_pkg::CMD_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == IDX_W'(NUM_TASKS - 1)) begin
               state_in = ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_miss_in  = rsp_miss_ff;
      if (load_go) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ets_pkg::KIND_LOAD;
         rsp_run_in   = 1'b0;
         rsp_task_in  = '0;
         rsp_miss_in  = '0;
      end else if (commit_go) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ets_pkg::KIND_TICK;
         rsp_run_in   = chain_found[NUM_TASKS];
         rsp_task_in  = chain_found[NUM_TASKS] ?
                        ets_pkg::RUN_TASK_W'(chain_pick[NUM_TASKS]) : '0;
         rsp_miss_in  = miss_mask_w;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.run_valid   = rsp_run_ff;
   assign rsp_chan.run_task    = rsp_task_ff;
   assign rsp_chan.miss_mask   = rsp_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         task_count_ff <= ets_pkg::TASK_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         task_count_ff <= task_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_task_ff <= rsp_task_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   // ---------------------------------------------------------------- cell row
   assign load_exec     = TIME_WIDTH'(req_chan.exec_time);
   assign load_deadline = TIME_WIDTH'(req_chan.rel_deadline);
   assign load_period   = TIME_WIDTH'(req_chan.period);

   assign chain_found[0] = 1'b0;
   assign chain_best[0]  = '0;
   assign chain_pick[0]  = '0;

   for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
      ets_pkg::cell_ctrl_type ctrl;
      logic                   active;

      assign win_vec[g]  = chain_found[NUM_TASKS] &&
                           (chain_pick[NUM_TASKS] == IDX_W'(g));
      assign ctrl.load   = load_go &&
                           (SEL_W'(req_chan.task_index) == SEL_W'(g));
      assign ctrl.commit = commit_go;
      assign ctrl.win    = commit_go && win_vec[g];
      // A count above NUM_TASKS activates every slot, zero activates none.
      assign active      = CMP_W'(g) < CMP_W'(task_count_ff);

      ets_cell #(
         .TIME_WIDTH (TIME_WIDTH),
         .IDX_W      (IDX_W),
         .CELL_IDX   (IDX_W'(g))
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .active         (active),
         .load_exec      (load_exec),
         .load_deadline  (load_deadline),
         .load_period    (load_period),
         .scan_in_found  (chain_found[g]),
         .scan_in_best   (chain_best[g]),
         .scan_in_pick   (chain_pick[g]),
         .scan_out_found (chain_found[g+1]),
         .scan_out_best  (chain_best[g+1]),
         .scan_out_pick  (chain_pick[g+1]),
         .miss           (miss_vec[g])
      );
   end

   for (genvar m = 0; m < ets_pkg::MISS_W; m++) begin : g_miss
      if (m < NUM_TASKS) begin : g_used
         assign miss_mask_w[m] = miss_vec[m];
      end else begin : g_unused
         assign miss_mask_w[m] = 1'b0;
      end
   end

   // ---------------------------------------------------------------- checks
   a_one_winner: assert property (@(posedge clock) disable iff (reset)
      $onehot0(win_vec))
      else $error("more than one task cell selected");

   a_tick_scans: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.cmd == ets_pkg::CMD_TICK)) |=> (state_ff == ST_SCAN))
      else $error("accepted tick did not start the scan");

   a_commit_responds: assert property (@(posedge clock) disable iff (reset)
      commit_go |=> (rsp_valid_ff && (rsp_kind_ff == ets_pkg::KIND_TICK)))
      else $error("committed tick produced no tick response");

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("request taken while a tick is in progress");

endmodule

`default_nettype wire
